FILE: rtl/core/ilp_pkg.sv
// Shared types and character constants for the integer literal parser.
package ilp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned POS_W   = 2;

    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;

    // character index, saturating at the third character
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_REST   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_BIN = 2'd2
    } format_kind_t;

    typedef struct packed {
        logic [3:0] dec_digit;
        logic       dec_legal;
        logic [3:0] hex_nibble;
        logic       hex_legal;
        logic       bin_bit;
        logic       bin_legal;
        logic       is_sign;
    } char_class_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               well_formed;
        format_kind_t       format_kind;
    } result_t;

endpackage

FILE: rtl/core/integer_literal_parser.sv
// Top level: input register, literal accumulator and result register.
// Path: a literal's last character word goes through the input register, then its
//   result is loaded into the result register.
// Throughput: one character word per cycle unless a last word waits for the output
//   slot; a single shift-add per word, so the input side never idles while the output flows.
// A result waiting in the output register stalls only a following last character.
// Reset (rst_n, async, active low) empties both registers and clears the literal state.
module integer_literal_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ilp_pkg::CHAR_W-1:0]  s_tdata,  // [7:0] char_code
    input  logic                        s_tlast,  // last_char
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ilp_pkg::VALUE_W-1:0] m_tdata,  // [63:0] value
    output logic [2:0]                  m_tuser   // [0] well_formed, [2:1] format_kind
);
    import ilp_pkg::*;

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;

    logic              out_free;
    logic              step;
    char_class_t       cls;
    result_t           res;

    assign out_free = !m_valid_reg || m_tready;
    // a non-last word never needs the output slot
    assign step     = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_tready = !s1_valid_reg || step;

    ilp_char_decode u_decode (
        .char_code (s1_char_reg),
        .cls       (cls)
    );

    ilp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (s1_char_reg),
        .last_char (s1_last_reg),
        .cls       (cls),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (step && s1_last_reg)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (step && s1_last_reg)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.value;
    assign m_tuser  = {m_res_reg.format_kind, m_res_reg.well_formed};

`ifndef ASSERT_OFF
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_last_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
        (step && s1_last_reg) |=> m_tvalid)
        else $error("last character did not produce a result");

    a_stall_holds_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s1_valid_reg && s1_last_reg) |-> !s_tready)
        else $error("last character advanced while output stalled");
`endif

endmodule

FILE: rtl/core/ilp_char_decode.sv
// Character classifier: digit values and legality for each number format.
module ilp_char_decode (
    input  logic [ilp_pkg::CHAR_W-1:0] char_code,
    output ilp_pkg::char_class_t       cls
);
    import ilp_pkg::*;

    logic is_dec;
    logic is_lower;
    logic is_upper;
    logic [CHAR_W-1:0] off_dec;
    logic [CHAR_W-1:0] off_lower;
    logic [CHAR_W-1:0] off_upper;

    always_comb
    begin
        is_dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_lower  = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F);
        is_upper  = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F);
        off_dec   = char_code - CH_ZERO;
        off_lower = char_code - CH_LOWER_A + 8'd10;
        off_upper = char_code - CH_UPPER_A + 8'd10;

        cls.dec_digit = is_dec ? off_dec[3:0] : 4'd0;
        cls.dec_legal = is_dec;
        if (is_dec)
        begin
            cls.hex_nibble = off_dec[3:0];
        end
        else if (is_lower)
        begin
            cls.hex_nibble = off_lower[3:0];
        end
        else if (is_upper)
        begin
            cls.hex_nibble = off_upper[3:0];
        end
        else
        begin
            cls.hex_nibble = 4'd0;
        end
        cls.hex_legal = is_dec || is_lower || is_upper;
        // anything but '0' shifts in a one
        cls.bin_bit   = (char_code != CH_ZERO);
        cls.bin_legal = (char_code == CH_ZERO) || (char_code == CH_ONE);
        cls.is_sign   = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    end

endmodule

FILE: rtl/core/ilp_accum.sv
// Literal state and the four accumulators; forms the result for the current word.
module ilp_accum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [ilp_pkg::CHAR_W-1:0] char_code,
    input  logic                       last_char,
    input  ilp_pkg::char_class_t       cls,
    output ilp_pkg::result_t           res
);
    import ilp_pkg::*;

    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [CHAR_W-1:0]  first_reg,  first_next;
    logic [CHAR_W-1:0]  second_reg, second_next;
    logic [VALUE_W-1:0] dec_reg,    dec_next;
    logic [VALUE_W-1:0] neg_reg,    neg_next;
    logic [VALUE_W-1:0] hex_reg,    hex_next;
    logic [VALUE_W-1:0] bin_reg,    bin_next;
    logic               dec_ok_reg, dec_ok_next;
    logic               hex_ok_reg, hex_ok_next;
    logic               bin_ok_reg, bin_ok_next;

    logic               at_first;
    logic               long_lit;
    logic               add_dec;
    logic [VALUE_W-1:0] digit_ext;
    logic [CHAR_W-1:0]  first_cur;
    logic               zero_prefix;

    always_comb
    begin
        at_first  = (pos_reg == POS_FIRST);
        long_lit  = (pos_reg == POS_REST);
        add_dec   = !(at_first && cls.is_sign);
        digit_ext = {{(VALUE_W-4){1'b0}}, cls.dec_digit};
        first_cur = at_first ? char_code : first_reg;

        // neg_reg tracks the negated decimal sum so a '-' needs no extra add
        dec_next    = dec_reg;
        neg_next    = neg_reg;
        dec_ok_next = dec_ok_reg;
        if (add_dec)
        begin
            dec_next    = (dec_reg << 3) + (dec_reg << 1) + digit_ext;
            neg_next    = (neg_reg << 3) + (neg_reg << 1) - digit_ext;
            dec_ok_next = dec_ok_reg && cls.dec_legal;
        end

        hex_next    = hex_reg;
        bin_next    = bin_reg;
        hex_ok_next = hex_ok_reg;
        bin_ok_next = bin_ok_reg;
        if (long_lit)
        begin
            hex_next    = {hex_reg[VALUE_W-5:0], cls.hex_nibble};
            bin_next    = {bin_reg[VALUE_W-2:0], cls.bin_bit};
            hex_ok_next = hex_ok_reg && cls.hex_legal;
            bin_ok_next = bin_ok_reg && cls.bin_legal;
        end

        first_next  = first_cur;
        second_next = (pos_reg == POS_SECOND) ? char_code : second_reg;
        pos_next    = long_lit ? POS_REST : pos_reg + 2'd1;

        zero_prefix = (first_cur == CH_ZERO);
        if (long_lit && ((second_reg == CH_LOWER_X) || (second_reg == CH_UPPER_X)))
        begin
            res.format_kind = KIND_HEX;
            res.well_formed = zero_prefix && hex_ok_next;
            res.value       = zero_prefix ? hex_next : '0;
        end
        else if (long_lit && ((second_reg == CH_LOWER_B) || (second_reg == CH_UPPER_B)))
        begin
            res.format_kind = KIND_BIN;
            res.well_formed = zero_prefix && bin_ok_next;
            res.value       = zero_prefix ? bin_next : '0;
        end
        else
        begin
            res.format_kind = KIND_DEC;
            res.well_formed = dec_ok_next;
            res.value       = (first_cur == CH_MINUS) ? neg_next : dec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            dec_reg    <= '0;
            neg_reg    <= '0;
            hex_reg    <= '0;
            bin_reg    <= '0;
            dec_ok_reg <= 1'b1;
            hex_ok_reg <= 1'b1;
            bin_ok_reg <= 1'b1;
        end
        else if (step)
        begin
            if (last_char)
            begin
                pos_reg    <= POS_FIRST;
                first_reg  <= '0;
                second_reg <= '0;
                dec_reg    <= '0;
                neg_reg    <= '0;
                hex_reg    <= '0;
                bin_reg    <= '0;
                dec_ok_reg <= 1'b1;
                hex_ok_reg <= 1'b1;
                bin_ok_reg <= 1'b1;
            end
            else
            begin
                pos_reg    <= pos_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                dec_reg    <= dec_next;
                neg_reg    <= neg_next;
                hex_reg    <= hex_next;
                bin_reg    <= bin_next;
                dec_ok_reg <= dec_ok_next;
                hex_ok_reg <= hex_ok_next;
                bin_ok_reg <= bin_ok_next;
            end
        end
    end

endmodule

FILE: test/literal_checker.sv
// Checker for the integer literal parser: tracks character words, predicts results, compares.
module literal_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [ilp_pkg::CHAR_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [ilp_pkg::VALUE_W-1:0] m_tdata,
    input  logic [2:0]                  m_tuser,
    output int                          errors,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ilp_pkg::*;

    logic [POS_W-1:0]   char_idx = POS_FIRST;
    logic [CHAR_W-1:0]  lead_char = '0;
    logic [CHAR_W-1:0]  prefix_char = '0;
    logic [VALUE_W-1:0] dec_sum = '0;
    logic [VALUE_W-1:0] hex_sum = '0;
    logic [VALUE_W-1:0] bin_sum = '0;
    bit                 dec_ok = 1'b1;
    bit                 hex_ok = 1'b1;
    bit                 bin_ok = 1'b1;
    result_t            expected_q[$];

    function void clear_literal();
        char_idx    = POS_FIRST;
        lead_char   = '0;
        prefix_char = '0;
        dec_sum     = '0;
        hex_sum     = '0;
        bin_sum     = '0;
        dec_ok      = 1'b1;
        hex_ok      = 1'b1;
        bin_ok      = 1'b1;
    endfunction

    function void add_decimal(input logic [CHAR_W-1:0] c);
        logic [VALUE_W-1:0] digit;
        digit = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
            digit = VALUE_W'(c - CH_ZERO);
        else
            dec_ok = 1'b0;
        dec_sum = dec_sum * 64'd10 + digit;
    endfunction

    task note_mismatch(input string what, input logic [VALUE_W-1:0] exp_v,
                       input logic [VALUE_W-1:0] act_v);
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [3:0] nibble;
        bit         long_lit;
        result_t    r;
        if (!rst_n)
        begin
            clear_literal();
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: value %h, flags %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    r = expected_q.pop_front();
                    checked++;
                    if (m_tdata !== r.value)
                        note_mismatch("value", r.value, m_tdata);
                    if (m_tuser[0] !== r.well_formed)
                        note_mismatch("well_formed", r.well_formed, m_tuser[0]);
                    if (m_tuser[2:1] !== r.format_kind)
                        note_mismatch("format_kind", r.format_kind, m_tuser[2:1]);
                end
            end

            if (s_tvalid && s_tready)
            begin
                long_lit = (char_idx == POS_REST);
                if (char_idx == POS_FIRST)
                begin
                    lead_char = s_tdata;
                    // a leading sign is not a digit
                    if (s_tdata != CH_PLUS && s_tdata != CH_MINUS)
                        add_decimal(s_tdata);
                    char_idx = POS_SECOND;
                end
                else if (char_idx == POS_SECOND)
                begin
                    prefix_char = s_tdata;
                    add_decimal(s_tdata);
                    char_idx = POS_REST;
                end
                else
                begin
                    add_decimal(s_tdata);
                    if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE)
                        nibble = 4'(s_tdata - CH_ZERO);
                    else if (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_F)
                        nibble = 4'(s_tdata - CH_LOWER_A + 8'd10);
                    else if (s_tdata >= CH_UPPER_A && s_tdata <= CH_UPPER_F)
                        nibble = 4'(s_tdata - CH_UPPER_A + 8'd10);
                    else
                    begin
                        nibble = '0;
                        hex_ok = 1'b0;
                    end
                    hex_sum = {hex_sum[VALUE_W-5:0], nibble};
                    // binary: anything but '0' shifts in a one
                    if (s_tdata != CH_ZERO && s_tdata != CH_ONE)
                        bin_ok = 1'b0;
                    bin_sum = {bin_sum[VALUE_W-2:0], s_tdata != CH_ZERO};
                end

                if (s_tlast)
                begin
                    if (long_lit && (prefix_char == CH_LOWER_X || prefix_char == CH_UPPER_X))
                    begin
                        r.format_kind = KIND_HEX;
                        r.well_formed = (lead_char == CH_ZERO) && hex_ok;
                        r.value       = (lead_char == CH_ZERO) ? hex_sum : '0;
                    end
                    else if (long_lit &&
                             (prefix_char == CH_LOWER_B || prefix_char == CH_UPPER_B))
                    begin
                        r.format_kind = KIND_BIN;
                        r.well_formed = (lead_char == CH_ZERO) && bin_ok;
                        r.value       = (lead_char == CH_ZERO) ? bin_sum : '0;
                    end
                    else
                    begin
                        r.format_kind = KIND_DEC;
                        r.well_formed = dec_ok;
                        r.value       = (lead_char == CH_MINUS) ? -dec_sum : dec_sum;
                    end
                    expected_q.push_back(r);
                    clear_literal();
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top: drives literals into the parser, stalls the result side, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ilp_pkg::*;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    localparam int RANDOM_CHARS = 1850;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;
    logic [2:0]         m_tuser;

    int errors;
    int pending;
    int checked;

    int burst_left = 0;
    int n_chars    = 0;
    int n_literals = 0;
    int n_dec      = 0;
    int n_hex      = 0;
    int n_bin      = 0;
    int n_odd      = 0;

    integer_literal_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    literal_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one character word; called and returns at a falling edge
    task automatic send_word(input logic [CHAR_W-1:0] c, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        n_chars++;
    endtask

    task automatic send_literal(input char_q_t lit);
        for (int i = 0; i < lit.size(); i++)
            send_word(lit[i], i == lit.size() - 1);
        n_literals++;
    endtask

    // result side: changing stall patterns plus two long hold-offs
    initial
    begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0)
                mode = $urandom_range(0, 3);
            if (cyc == 600 || cyc == 2000)
            begin
                m_tready <= 1'b0;
                repeat (250) @(negedge clk);
                cyc += 250;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        string   directed[$];
        char_q_t lit;
        int      start_chars;
        int      r;
        int      n;
        int      v;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone sign, short prefix, mixed-case hex letters, bad binary digit, bad prefix,
        // decimal junk with negation
        directed = '{"-", "+9", "0x", "0xfF", "0b12", "1x5", "-1z"};
        foreach (directed[i])
        begin
            lit.delete();
            for (int k = 0; k < directed[i].len(); k++)
                lit.push_back(directed[i][k]);
            send_literal(lit);
        end
        lit = '{8'h00};
        send_literal(lit);
        lit = '{CH_ZERO, CH_UPPER_X, 8'hff};
        send_literal(lit);

        start_chars = n_chars;
        while (n_chars - start_chars < RANDOM_CHARS)
        begin
            r = $urandom_range(0, 99);
            lit.delete();
            if (r < 88)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        v = $urandom_range(0, 2);
                        if (v == 1)
                            lit.push_back(CH_PLUS);
                        else if (v == 2)
                            lit.push_back(CH_MINUS);
                        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                        : $urandom_range(1, 8);
                        repeat (n)
                            lit.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        if (r < 76)
                            n_dec++;
                    end
                    1:
                    begin
                        lit.push_back(CH_ZERO);
                        lit.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18)
                                                        : $urandom_range(0, 8);
                        repeat (n)
                        begin
                            v = $urandom_range(0, 21);
                            if (v < 10)
                                lit.push_back(8'(CH_ZERO + v));
                            else if (v < 16)
                                lit.push_back(8'(CH_LOWER_A + v - 10));
                            else
                                lit.push_back(8'(CH_UPPER_A + v - 16));
                        end
                        if (r < 76)
                            n_hex++;
                    end
                    default:
                    begin
                        lit.push_back(CH_ZERO);
                        lit.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
                        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 66)
                                                        : $urandom_range(0, 16);
                        repeat (n)
                            lit.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
                        if (r < 76)
                            n_bin++;
                    end
                endcase
                // corrupt one character of an otherwise clean literal
                if (r >= 76)
                begin
                    lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
                    n_odd++;
                end
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    lit.push_back(8'($urandom_range(0, 255)));
                n_odd++;
            end
            send_literal(lit);
        end

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run: %0d characters in %0d literals (%0d decimal, %0d hex, %0d binary,",
                 n_chars, n_literals, n_dec, n_hex, n_bin);
        $display("     %0d corrupted or random), %0d results checked, %0d mismatches",
                 n_odd, checked, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ilp_pkg.sv
rtl/core/ilp_char_decode.sv
rtl/core/ilp_accum.sv
rtl/core/integer_literal_parser.sv
test/literal_checker.sv
test/tb.sv
